@@ src/fba_pkg.sv @@
`default_nettype none

package fba_pkg;

   localparam int NUM_BLOCKS_DEF = 1024;
   localparam int DATA_START_DEF = 5;
   localparam int ROOT_BLOCK_DEF = 5;

   localparam int OP_W  = 2;
   localparam int IDX_W = 10;

   localparam logic [OP_W-1:0] OP_FORMAT = 2'd0;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

   typedef logic [OP_W-1:0]  op_type;
   typedef logic [IDX_W-1:0] idx_type;

endpackage

`default_nettype wire

@@ src/fba_if.sv @@
`default_nettype none

interface fba_req_if
   import fba_pkg::*;
();
   logic    valid;
   logic    ready;
   op_type  op;
   idx_type start_block;

   modport source (output valid, output op, output start_block, input ready);
   modport sink   (input valid, input op, input start_block, output ready);
endinterface

interface fba_rsp_if
   import fba_pkg::*;
();
   logic    valid;
   logic    ready;
   idx_type block_index;
   logic    found;
   logic    overrun;

   modport source (output valid, output block_index, output found, output overrun,
                   input ready);
   modport sink   (input valid, input block_index, input found, input overrun,
                   output ready);
endinterface

`default_nettype wire

@@ src/fba_map_mem.sv @@
`default_nettype none

module fba_map_mem
   import fba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   localparam int AW = $clog2(NUM_BLOCKS)
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic               rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic          wr_data
);

   logic mem [NUM_BLOCKS];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/fat_block_allocator_core.sv @@
`default_nettype none

// channel   dir  payload                          beat
// req_chan  in   op, start_block                  one operation
// rsp_chan  out  block_index, found, overrun      one result per operation
//
// One operation at a time; the map is a 1-bit-wide single-port-read memory.
// Format writes one entry a cycle.
// Find reads one entry a cycle from block 0, free-run from start_block.
// After reset a format pass over every entry runs before req_chan.ready rises.
// A stalled rsp_chan holds the finished result; the next result waits for it in S_DONE.

module fat_block_allocator_core
   import fba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   parameter int DATA_START = DATA_START_DEF,
   parameter int ROOT_BLOCK = ROOT_BLOCK_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fba_req_if.sink    req_chan,
   fba_rsp_if.source  rsp_chan
);

   localparam int AW = $clog2(NUM_BLOCKS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BLOCKS - 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_FORMAT = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] paddr_ff, paddr_in;
   logic          issue_ff, issue_in;
   logic          pend_ff, pend_in;
   logic          find_ff, find_in;
   logic          rsp_valid_ff, rsp_valid_in;

   idx_type       res_idx_ff, res_idx_in;
   logic          res_fnd_ff, res_fnd_in;
   logic          res_ovr_ff, res_ovr_in;
   idx_type       out_idx_ff, out_idx_in;
   logic          out_fnd_ff, out_fnd_in;
   logic          out_ovr_ff, out_ovr_in;

   logic          mem_rd_en;
   logic          mem_rd_data;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic          mem_wr_data;

   logic [31:0]   cnt32;
   logic [31:0]   start32;
   logic [31:0]   paddr32;
   logic          fmt_free;
   logic          hit;
   logic          out_free;

   assign cnt32   = {{(32-AW){1'b0}}, cnt_ff};
   assign paddr32 = {{(32-AW){1'b0}}, paddr_ff};
   assign start32 = {{(32-IDX_W){1'b0}}, req_chan.start_block};
   assign fmt_free = (cnt32 >= 32'(DATA_START)) && (cnt32 != 32'(ROOT_BLOCK));
   assign hit = find_ff ? mem_rd_data : !mem_rd_data;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == S_IDLE);

   fba_map_mem #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_map (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (cnt_ff),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      paddr_in     = paddr_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      find_in      = find_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      res_idx_in   = res_idx_ff;
      res_fnd_in   = res_fnd_ff;
      res_ovr_in   = res_ovr_ff;
      out_idx_in   = out_idx_ff;
      out_fnd_in   = out_fnd_ff;
      out_ovr_in   = out_ovr_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = cnt_ff;
      mem_wr_data  = fmt_free;

      unique case (state_ff)
         S_CLEAR, S_FORMAT: begin
            mem_wr_en = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = (state_ff == S_CLEAR) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            res_idx_in = '0;
            res_fnd_in = 1'b0;
            res_ovr_in = 1'b0;
            if (req_chan.valid) begin
               case (req_chan.op)
                  OP_FORMAT: begin
                     cnt_in   = '0;
                     state_in = S_FORMAT;
                  end
                  OP_FIND: begin
                     cnt_in   = '0;
                     find_in  = 1'b1;
                     issue_in = 1'b1;
                     state_in = S_SCAN;
                  end
                  OP_FREE: begin
                     if (start32 >= 32'(NUM_BLOCKS)) begin
                        res_ovr_in = 1'b1;
                        state_in   = S_DONE;
                     end else begin
                        cnt_in   = start32[AW-1:0];
                        find_in  = 1'b0;
                        issue_in = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            mem_rd_en = issue_ff;
            if (issue_ff) begin
               cnt_in   = cnt_ff + 1'b1;
               paddr_in = cnt_ff;
               pend_in  = 1'b1;
               issue_in = (cnt_ff != LAST_ADDR);
            end
            if (pend_ff && (hit || paddr_ff == LAST_ADDR)) begin
               issue_in = 1'b0;
               pend_in  = 1'b0;
               state_in = S_DONE;
               if (find_ff) begin
                  res_fnd_in = hit;
                  res_idx_in = hit ? paddr32[IDX_W-1:0] : '0;
               end else begin
                  res_ovr_in  = !hit;
                  mem_wr_en   = hit;
                  mem_wr_addr = paddr_ff;
                  mem_wr_data = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_idx_in   = res_idx_ff;
               out_fnd_in   = res_fnd_ff;
               out_ovr_in   = res_ovr_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         find_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         find_ff      <= find_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      paddr_ff   <= paddr_in;
      res_idx_ff <= res_idx_in;
      res_fnd_ff <= res_fnd_in;
      res_ovr_ff <= res_ovr_in;
      out_idx_ff <= out_idx_in;
      out_fnd_ff <= out_fnd_in;
      out_ovr_ff <= out_ovr_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.block_index = out_idx_ff;
   assign rsp_chan.found       = out_fnd_ff;
   assign rsp_chan.overrun     = out_ovr_ff;

endmodule

`default_nettype wire

@@ tb/sv/fat_block_allocator_core_tb.sv @@
`timescale 1ns / 100ps

module fat_block_allocator_core_tb;
   import fba_pkg::*;

   localparam int NUM_BLOCKS  = NUM_BLOCKS_DEF;
   localparam int DATA_START  = DATA_START_DEF;
   localparam int ROOT_BLOCK  = ROOT_BLOCK_DEF;
   localparam int RANDOM_OPS  = 557;
   localparam int REPORT_MAX  = 10;
   localparam int IDLE_LIMIT  = 8 * (NUM_BLOCKS + 64);
   localparam op_type OP_UNUSED = 2'd3;

   typedef struct packed {
      idx_type block_index;
      logic    found;
      logic    overrun;
   } map_result_type;

   typedef enum {RSP_FLOW, RSP_CHOPPY, RSP_CHOKED} rsp_mode_type;

   // Block map model plus the queue of results it predicts.
   class block_map_checker;
      bit             free_map [NUM_BLOCKS];
      map_result_type expected_results [$];
      int             mismatches;

      function new();
         mismatches = 0;
         format_map();
      endfunction

      function void format_map();
         for (int b = 0; b < NUM_BLOCKS; b++)
            free_map[b] = (b >= DATA_START);
         if (ROOT_BLOCK < NUM_BLOCKS)
            free_map[ROOT_BLOCK] = 1'b0;
      endfunction

      function void note_op(op_type op, idx_type start);
         map_result_type r;
         r = '0;
         case (op)
            OP_FORMAT: format_map();
            OP_FIND: begin
               for (int b = 0; b < NUM_BLOCKS; b++) begin
                  if (free_map[b]) begin
                     r.block_index = idx_type'(b);
                     r.found       = 1'b1;
                     break;
                  end
               end
            end
            OP_FREE: begin
               r.overrun = 1'b1;
               for (int b = int'(start); b < NUM_BLOCKS; b++) begin
                  if (!free_map[b]) begin
                     free_map[b] = 1'b1;
                     r.overrun   = 1'b0;
                     break;
                  end
               end
            end
            default: ;
         endcase
         expected_results.push_back(r);
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void check_result(idx_type idx, logic fnd, logic ovr);
         map_result_type e;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: unexpected result idx=%0d found=%0b overrun=%0b",
                        $realtime, idx, fnd, ovr);
            return;
         end
         e = expected_results.pop_front();
         if (idx !== e.block_index || fnd !== e.found || ovr !== e.overrun) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: mismatch exp idx/fnd/ovr=%0d/%0b/%0b got %0d/%0b/%0b",
                        $realtime, e.block_index, e.found, e.overrun, idx, fnd, ovr);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   fba_req_if req_bus ();
   fba_rsp_if rsp_bus ();

   fat_block_allocator_core #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .DATA_START (DATA_START),
      .ROOT_BLOCK (ROOT_BLOCK)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   block_map_checker map_chk = new();

   int           burst_left = 0;
   int           hold_left  = 0;
   rsp_mode_type hold_mode  = RSP_FLOW;
   int           idle_cycles = 0;

   op_type  dir_op    [23] = '{OP_FIND, OP_FREE, OP_FIND, OP_FREE, OP_FREE, OP_FREE,
                               OP_FREE, OP_UNUSED, OP_UNUSED, OP_FORMAT, OP_FIND,
                               OP_FREE, OP_FREE, OP_FREE, OP_FREE, OP_FREE, OP_FREE,
                               OP_FREE, OP_FREE, OP_FREE, OP_FIND, OP_FORMAT, OP_FIND};
   idx_type dir_start [23] = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd5, 10'd6,
                               10'd1023, 10'd1023, 10'd0, 10'd1023, 10'h2AA,
                               10'd1000, 10'd4, 10'h155, 10'd2, 10'd2, 10'd0,
                               10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023};

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   // beat accounting for the watchdog
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         map_chk.check_result(rsp_bus.block_index, rsp_bus.found, rsp_bus.overrun);
   end

   // result-side backpressure: segments of free flow, choppy and mostly stalled
   always @(negedge clock) begin
      if (hold_left == 0) begin
         hold_mode = rsp_mode_type'($urandom_range(0, 2));
         hold_left = $urandom_range(1, 64);
      end
      hold_left--;
      case (hold_mode)
         RSP_FLOW:   rsp_bus.ready <= 1'b1;
         RSP_CHOPPY: rsp_bus.ready <= 1'($urandom_range(0, 1));
         default:    rsp_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic send_op(input op_type op, input idx_type start);
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.start_block <= start;
      do @(posedge clock); while (!req_bus.ready);
      map_chk.note_op(op, start);
      @(negedge clock);
   endtask

   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (map_chk.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int      roll;
      op_type  op;
      idx_type start;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_FORMAT;
      req_bus.start_block = '0;
      rsp_bus.ready       = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_op[i]) begin
         pace_sender();
         send_op(dir_op[i], dir_start[i]);
      end
      drain_results();

      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 128 == 127)
            drain_results();
         roll = $urandom_range(0, 99);
         if (roll < 8)
            op = OP_FORMAT;
         else if (roll < 40)
            op = OP_FIND;
         else if (roll < 92)
            op = OP_FREE;
         else
            op = OP_UNUSED;
         roll = $urandom_range(0, 99);
         if (roll < 60)
            start = idx_type'($urandom_range(0, 7));
         else if (roll < 75)
            start = idx_type'($urandom_range(NUM_BLOCKS - 8, NUM_BLOCKS - 1));
         else
            start = idx_type'($urandom_range(0, NUM_BLOCKS - 1));
         pace_sender();
         send_op(op, start);
      end

      drain_results();
      repeat (NUM_BLOCKS + 16) @(posedge clock);
      if (map_chk.mismatches == 0 && map_chk.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
